// File: design/euc_jp_to_shift_jis_stream_assert.svh
// Assertion macros used by the checker file of the EUC-JP to Shift-JIS converter.
`ifndef EUC_JP_TO_SHIFT_JIS_STREAM_ASSERT_SVH
`define EUC_JP_TO_SHIFT_JIS_STREAM_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define EJSJ_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition on one edge implies a condition on the next edge.
`define EJSJ_ASSERT_NEXT(label, cond, prop, msg) \
    `EJSJ_ASSERT_CLK(label, (cond) |=> (prop), msg)

`endif

// File: design/ejsj_pkg.sv
// Shared types for the EUC-JP to Shift-JIS converter.
package ejsj_pkg;

    // Results of one accepted input byte. The third result, when present, is
    // always the zero terminator, so only two bytes are stored.
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [1:0] cnt;
        logic       term;
    } ejsj_pkt_t;

    localparam logic [1:0] IDX_FIRST  = 2'd0;
    localparam logic [1:0] IDX_SECOND = 2'd1;

endpackage

// File: design/ejsj_front.sv
// Front end: accepts EUC-JP bytes, tracks lead and skip state, builds result packets.
module ejsj_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tlast,
    input  logic                  q_full,
    output logic                  push,
    output ejsj_pkg::ejsj_pkt_t   pkt
);
    import ejsj_pkg::*;

    localparam logic [7:0] BIT7       = 8'h80;
    localparam logic [7:0] KANA_LEAD  = 8'h8E;
    localparam logic [7:0] TRAIL_EDGE = 8'h5F;
    localparam logic [7:0] TRAIL_LO   = 8'h1F;
    localparam logic [7:0] TRAIL_HI   = 8'h20;
    localparam logic [7:0] TRAIL_EVEN = 8'h7E;
    localparam logic [8:0] LEAD_BIAS  = 9'h0E1;
    localparam logic [7:0] GAP_LO     = 8'hA0;
    localparam logic [7:0] GAP_HI     = 8'hDF;
    localparam logic [7:0] GAP_SHIFT  = 8'h40;

    logic [7:0] held_lead_reg, held_lead_next;
    logic       lead_pending_reg, lead_pending_next;
    logic       skipping_reg, skipping_next;

    logic       accept;
    logic [7:0] kj_lead, kj_trail;
    logic [7:0] l7, t7;
    logic [8:0] lead_sum;
    logic [7:0] lead_half;
    logic [7:0] mb0, mb1;
    logic [1:0] main_cnt;
    logic       ended;
    logic       fin;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // JIS to Shift-JIS arithmetic on the held lead and the incoming trail byte.
    always_comb
    begin
        l7 = held_lead_reg & ~BIT7;
        t7 = s_tdata & ~BIT7;
        if (l7[0])
        begin
            kj_trail = (t7 <= TRAIL_EDGE) ? t7 + TRAIL_LO : t7 + TRAIL_HI;
        end
        else
        begin
            kj_trail = t7 + TRAIL_EVEN;
        end
        lead_sum  = {1'b0, l7} + LEAD_BIAS;
        lead_half = lead_sum[8:1];
        if (lead_half >= GAP_LO && lead_half <= GAP_HI)
        begin
            kj_lead = lead_half + GAP_SHIFT;
        end
        else
        begin
            kj_lead = lead_half;
        end
    end

    always_comb
    begin
        held_lead_next    = held_lead_reg;
        lead_pending_next = lead_pending_reg;
        skipping_next     = skipping_reg;
        mb0      = 8'h00;
        mb1      = 8'h00;
        main_cnt = 2'd0;
        ended    = 1'b0;
        fin      = 1'b0;
        if (skipping_reg)
        begin
            skipping_next = !s_tlast;
        end
        else
        begin
            if (lead_pending_reg)
            begin
                lead_pending_next = 1'b0;
                held_lead_next    = 8'h00;
                if (s_tdata == 8'h00)
                begin
                    mb0      = held_lead_reg;
                    main_cnt = 2'd1;
                    ended    = 1'b1;
                end
                else if (held_lead_reg == KANA_LEAD)
                begin
                    mb0      = s_tdata;
                    main_cnt = 2'd1;
                end
                else
                begin
                    mb0      = kj_lead;
                    mb1      = kj_trail;
                    main_cnt = 2'd2;
                end
            end
            else if (s_tdata == 8'h00)
            begin
                ended = 1'b1;
            end
            else if (s_tdata[7])
            begin
                if (s_tlast)
                begin
                    mb0      = s_tdata;
                    main_cnt = 2'd1;
                end
                else
                begin
                    held_lead_next    = s_tdata;
                    lead_pending_next = 1'b1;
                end
            end
            else
            begin
                mb0      = s_tdata;
                main_cnt = 2'd1;
            end
            fin = ended || s_tlast;
            if (ended && !s_tlast)
            begin
                skipping_next = 1'b1;
            end
        end
    end

    // Unused byte slots stay zero, so the terminator needs no slot of its own.
    always_comb
    begin
        pkt.b0   = mb0;
        pkt.b1   = mb1;
        pkt.term = fin;
        pkt.cnt  = main_cnt + {1'b0, fin};
        push     = accept && (pkt.cnt != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_lead_reg    <= 8'h00;
            lead_pending_reg <= 1'b0;
            skipping_reg     <= 1'b0;
        end
        else if (accept)
        begin
            held_lead_reg    <= held_lead_next;
            lead_pending_reg <= lead_pending_next;
            skipping_reg     <= skipping_next;
        end
    end

endmodule

// File: design/ejsj_queue.sv
// Packet queue between the front end and the output serializer.
module ejsj_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ejsj_pkg::ejsj_pkt_t   push_pkt,
    output logic                  full,
    input  logic                  pop,
    output ejsj_pkg::ejsj_pkt_t   head_pkt,
    output logic                  empty
);
    import ejsj_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ejsj_pkt_t        slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_pkt = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_pkt;
        end
    end

endmodule

// File: design/ejsj_back.sv
// Back end: walks the head packet one byte per cycle into the output register while the output is not stalled.
module ejsj_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ejsj_pkg::ejsj_pkt_t   head_pkt,
    input  logic                  empty,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser
);
    import ejsj_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;
    logic       m_tuser_reg;

    logic       load;
    logic       final_byte;
    logic [7:0] sel_byte;

    assign load       = !empty && (!m_tvalid_reg || m_tready);
    assign final_byte = ((idx_reg + 2'd1) == head_pkt.cnt);
    assign pop        = load && final_byte;

    always_comb
    begin
        case (idx_reg)
            IDX_FIRST:  sel_byte = head_pkt.b0;
            IDX_SECOND: sel_byte = head_pkt.b1;
            default:    sel_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg;
        if (load)
        begin
            idx_next      = final_byte ? IDX_FIRST : idx_reg + 2'd1;
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= IDX_FIRST;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_tdata_reg <= sel_byte;
            m_tlast_reg <= final_byte;
            m_tuser_reg <= final_byte && head_pkt.term;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: design/euc_jp_to_shift_jis_stream.sv
// Top level of the EUC-JP to Shift-JIS byte stream converter.
//
//   Channel  Direction  Payload
//   s_*      in         tdata = in_byte, tlast = end_of_text
//   m_*      out        tdata = out_byte, tlast = run_last, tuser = text_done
//
// One input byte is taken per cycle while the packet queue has room; it gives
// zero to three output bytes, and the serializer sends one byte per cycle while
// the output is ready, so the sustained rate is one byte per cycle either side,
// limited by the output port. An input byte passes through a queue slot and the
// output register before its first output byte appears. Reset clears lead, skip
// and queue state; output stalls back up into the queue and only then hold the input.
module euc_jp_to_shift_jis_stream #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,
    output logic       m_tuser    // [0] text_done
);
    import ejsj_pkg::*;

    ejsj_pkt_t push_pkt;
    ejsj_pkt_t head_pkt;
    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_empty;

    ejsj_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .pkt      (push_pkt)
    );

    ejsj_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_pkt (push_pkt),
        .full     (q_full),
        .pop      (pop),
        .head_pkt (head_pkt),
        .empty    (q_empty)
    );

    ejsj_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_pkt (head_pkt),
        .empty    (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// File: design/ejsj_checker.sv
// Port-level checker for the EUC-JP to Shift-JIS converter, with its bind.
`include "euc_jp_to_shift_jis_stream_assert.svh"

module ejsj_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);
    // Output bytes already sent in the current run, which is at most three long.
    logic [1:0] run_len_reg, run_len_next;
    logic       out_take;
    logic       in_take;

    assign out_take = m_tvalid && m_tready;
    assign in_take  = s_tvalid && s_tready && (s_tdata != 8'h00) && !s_tlast;

    always_comb
    begin
        run_len_next = run_len_reg;
        if (out_take)
        begin
            run_len_next = m_tlast ? 2'd0 : run_len_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_len_reg <= 2'd0;
        end
        else
        begin
            run_len_reg <= run_len_next;
        end
    end

    `EJSJ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "output request changed while stalled")
    `EJSJ_ASSERT_CLK(a_term_form, m_tvalid && m_tuser |-> m_tdata == 8'h00 && m_tlast, "terminator is not a zero byte ending its run")
    `EJSJ_ASSERT_CLK(a_run_len, out_take && run_len_reg == 2'd2 |-> m_tlast, "more than three results in one run")
    `EJSJ_ASSERT_CLK(a_run_len_limit, in_take |-> run_len_reg != 2'd3, "run counter out of range")

endmodule

bind euc_jp_to_shift_jis_stream ejsj_checker u_checker (.*);

// File: bench/tb_euc_jp_to_shift_jis_stream.sv
// Self-checking testbench for the EUC-JP to Shift-JIS byte stream converter.
`timescale 1ns / 100ps

module tb_euc_jp_to_shift_jis_stream;

    localparam logic [7:0] TEXT_END    = 8'h00;
    localparam logic [7:0] KANA_LEAD   = 8'h8E;
    localparam int         IDLE_PCT    = 21;
    localparam int         ITEM_TARGET = 372;
    localparam int         TAIL_CYCLES = 20;
    localparam int         WATCHDOG    = 2000;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_done;
    } sjis_t;

    // One request to the converter. When fixed is set, the first count entries
    // of res are the hand-written results; otherwise the predictor decides.
    typedef struct packed {
        logic [7:0]      in_byte;
        logic            end_of_text;
        logic            fixed;
        logic [1:0]      count;
        sjis_t [1:0]     res;
    } row_t;

    localparam sjis_t NONE = '0;

    logic       clk;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    // Predictor state.
    logic [7:0] held_byte = 8'h00;
    logic       lead_held = 1'b0;
    logic       skip_rest = 1'b0;

    sjis_t step_out [$];
    sjis_t sjis_due [$];
    row_t  sent_rows [$];
    row_t  script [$];
    row_t  taken;

    logic steady = 1'b0;
    int   bytes_sent   = 0;
    int   table_rows   = 0;
    int   sjis_seen    = 0;
    int   texts_closed = 0;
    int   errors       = 0;
    int   idle_cycles  = 0;

    euc_jp_to_shift_jis_stream u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic sjis_t sj(input logic [7:0] b, input logic l, input logic d);
        sjis_t r;
        r.out_byte  = b;
        r.run_last  = l;
        r.text_done = d;
        return r;
    endfunction

    function automatic row_t by_model(input logic [7:0] b, input logic eot);
        row_t r;
        r             = '0;
        r.in_byte     = b;
        r.end_of_text = eot;
        return r;
    endfunction

    function automatic row_t typed_row(input logic [7:0] b, input logic eot,
                                       input logic [1:0] n, input sjis_t r0, input sjis_t r1);
        row_t r;
        r        = by_model(b, eot);
        r.fixed  = 1'b1;
        r.count  = n;
        r.res[0] = r0;
        r.res[1] = r1;
        return r;
    endfunction

    // Works out the Shift-JIS bytes that one EUC-JP byte causes.
    function automatic void convert_byte(input logic [7:0] c, input logic eot);
        logic       ended;
        logic [7:0] lo;
        logic [7:0] tr;
        logic [8:0] sum;
        sjis_t      tail;
        step_out.delete();
        ended = 1'b0;
        if (skip_rest)
        begin
            if (eot)
                skip_rest = 1'b0;
        end
        else
        begin
            if (lead_held)
            begin
                lead_held = 1'b0;
                if (c == TEXT_END)
                begin
                    step_out.push_back(sj(held_byte, 1'b0, 1'b0));
                    ended = 1'b1;
                end
                else if (held_byte == KANA_LEAD)
                begin
                    step_out.push_back(sj(c, 1'b0, 1'b0));
                end
                else
                begin
                    lo = {1'b0, held_byte[6:0]};
                    tr = {1'b0, c[6:0]};
                    // Odd JIS rows use the low trail range, even rows the high one.
                    if (lo[0])
                        tr = (tr <= 8'h5F) ? tr + 8'h1F : tr + 8'h20;
                    else
                        tr = tr + 8'h7E;
                    sum = ({1'b0, lo} + 9'h0E1) >> 1;
                    lo  = sum[7:0];
                    // Lead bytes skip over the half-width kana range.
                    if (lo >= 8'hA0 && lo <= 8'hDF)
                        lo = lo + 8'h40;
                    step_out.push_back(sj(lo, 1'b0, 1'b0));
                    step_out.push_back(sj(tr, 1'b0, 1'b0));
                end
                held_byte = 8'h00;
            end
            else if (c == TEXT_END)
                ended = 1'b1;
            else if (c[7])
            begin
                if (eot)
                    step_out.push_back(sj(c, 1'b0, 1'b0));
                else
                begin
                    held_byte = c;
                    lead_held = 1'b1;
                end
            end
            else
                step_out.push_back(sj(c, 1'b0, 1'b0));

            if (ended || eot)
            begin
                step_out.push_back(sj(TEXT_END, 1'b0, 1'b1));
                if (!eot)
                    skip_rest = 1'b1;
            end
        end
        if (step_out.size() > 0)
        begin
            tail          = step_out.pop_back();
            tail.run_last = 1'b1;
            step_out.push_back(tail);
        end
    endfunction

    function automatic void note_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Output side: ready drops in about a fifth of the cycles outside the steady stretch.
    always @(posedge clk)
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles++;
            if (s_tvalid && s_tready)
            begin
                idle_cycles = 0;
                taken = sent_rows.pop_front();
                convert_byte(s_tdata, s_tlast);
                if (taken.fixed)
                begin
                    for (int k = 0; k < taken.count; k++)
                        sjis_due.push_back(taken.res[k]);
                end
                else
                begin
                    foreach (step_out[k])
                        sjis_due.push_back(step_out[k]);
                end
            end
            if (m_tvalid && m_tready)
            begin
                idle_cycles = 0;
                sjis_seen++;
                if (m_tuser)
                    texts_closed++;
                if (sjis_due.size() == 0)
                begin
                    $display("%0t: unexpected byte, expected none, got %0h last %b done %b",
                             $time, m_tdata, m_tlast, m_tuser);
                    errors++;
                end
                else
                begin
                    taken.res[0] = sjis_due.pop_front();
                    note_field("out_byte", int'(taken.res[0].out_byte), int'(m_tdata));
                    note_field("run_last", int'(taken.res[0].run_last), int'(m_tlast));
                    note_field("text_done", int'(taken.res[0].text_done), int'(m_tuser));
                end
            end
            if (idle_cycles >= WATCHDOG)
            begin
                $display("%0t: no transfer for %0d cycles, %0d bytes still due",
                         $time, WATCHDOG, sjis_due.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Presents one request and returns at the edge where it is accepted.
    task automatic feed(input row_t r);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        sent_rows.push_back(r);
        s_tvalid <= 1'b1;
        s_tdata  <= r.in_byte;
        s_tlast  <= r.end_of_text;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
    endtask

    task automatic await_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sjis_due.size() != 0);
    endtask

    // A random text made mostly of well-formed characters, with a random ending.
    task automatic send_text();
        int chars;
        int kind;
        int junk;
        chars = $urandom_range(12, 1);
        for (int k = 0; k < chars; k++)
        begin
            kind = $urandom_range(9, 0);
            if (kind < 4)
                feed(by_model(8'($urandom_range(8'h7F, 8'h01)), 1'b0));
            else if (kind < 8)
            begin
                feed(by_model(8'($urandom_range(8'hFE, 8'hA1)), 1'b0));
                feed(by_model(8'($urandom_range(8'hFE, 8'hA1)), 1'b0));
            end
            else if (kind == 8)
            begin
                feed(by_model(KANA_LEAD, 1'b0));
                feed(by_model(8'($urandom_range(8'hDF, 8'hA1)), 1'b0));
            end
            else
                feed(by_model(8'($urandom_range(255, 0)), 1'b0));
        end
        case ($urandom_range(3, 0))
            0, 1: feed(by_model(TEXT_END, 1'b1));
            2: feed(by_model(8'($urandom_range(255, 1)), 1'b1));
            default:
            begin
                // Early end: the rest of the text up to the flagged byte is dropped.
                feed(by_model(TEXT_END, 1'b0));
                junk = $urandom_range(4, 0);
                for (int k = 0; k < junk; k++)
                    feed(by_model(8'($urandom_range(255, 0)), 1'b0));
                feed(by_model(8'($urandom_range(255, 0)), 1'b1));
            end
        endcase
    endtask

    initial
    begin
        logic paused;
        int   burst;
        paused = 1'b0;

        script.push_back(typed_row(8'h41, 1'b0, 2'd1, sj(8'h41, 1'b1, 1'b0), NONE));
        script.push_back(typed_row(8'h7F, 1'b0, 2'd1, sj(8'h7F, 1'b1, 1'b0), NONE));
        script.push_back(typed_row(8'h01, 1'b0, 2'd1, sj(8'h01, 1'b1, 1'b0), NONE));
        script.push_back(typed_row(8'hA4, 1'b0, 2'd0, NONE, NONE));
        script.push_back(by_model(8'hA2, 1'b0));
        script.push_back(typed_row(KANA_LEAD, 1'b0, 2'd0, NONE, NONE));
        script.push_back(typed_row(8'hB1, 1'b0, 2'd1, sj(8'hB1, 1'b1, 1'b0), NONE));
        script.push_back(typed_row(8'hFF, 1'b0, 2'd0, NONE, NONE));
        script.push_back(by_model(8'hFF, 1'b0));
        script.push_back(typed_row(8'h80, 1'b0, 2'd0, NONE, NONE));
        script.push_back(by_model(8'h80, 1'b0));
        script.push_back(by_model(8'hA1, 1'b0));
        script.push_back(by_model(8'hDF, 1'b0));
        script.push_back(by_model(8'hB0, 1'b0));
        script.push_back(by_model(8'hE0, 1'b0));
        // A zero byte not flagged last ends the text early.
        script.push_back(typed_row(TEXT_END, 1'b0, 2'd1, sj(TEXT_END, 1'b1, 1'b1), NONE));
        script.push_back(typed_row(8'h55, 1'b0, 2'd0, NONE, NONE));
        script.push_back(typed_row(8'h20, 1'b1, 2'd0, NONE, NONE));
        script.push_back(typed_row(8'hC8, 1'b0, 2'd0, NONE, NONE));
        script.push_back(typed_row(TEXT_END, 1'b0, 2'd2, sj(8'hC8, 1'b0, 1'b0),
                                   sj(TEXT_END, 1'b1, 1'b1)));
        script.push_back(typed_row(8'h33, 1'b1, 2'd0, NONE, NONE));
        script.push_back(typed_row(8'hD5, 1'b1, 2'd2, sj(8'hD5, 1'b0, 1'b0),
                                   sj(TEXT_END, 1'b1, 1'b1)));
        script.push_back(typed_row(8'h42, 1'b1, 2'd2, sj(8'h42, 1'b0, 1'b0),
                                   sj(TEXT_END, 1'b1, 1'b1)));
        script.push_back(typed_row(TEXT_END, 1'b1, 2'd1, sj(TEXT_END, 1'b1, 1'b1), NONE));
        // Kanji pair closed by the flag gives the most results per request.
        script.push_back(typed_row(8'hE9, 1'b0, 2'd0, NONE, NONE));
        script.push_back(by_model(8'h31, 1'b1));
        script.push_back(typed_row(KANA_LEAD, 1'b0, 2'd0, NONE, NONE));
        script.push_back(typed_row(TEXT_END, 1'b1, 2'd2, sj(KANA_LEAD, 1'b0, 1'b0),
                                   sj(TEXT_END, 1'b1, 1'b1)));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            feed(script[i]);
        table_rows = bytes_sent;
        await_results();

        while (bytes_sent < ITEM_TARGET)
        begin
            steady = (bytes_sent >= 200 && bytes_sent < 290);
            if ($urandom_range(99) < 80)
                send_text();
            else
            begin
                burst = $urandom_range(6, 1);
                for (int k = 0; k < burst; k++)
                    feed(by_model(8'($urandom_range(255, 0)), $urandom_range(7, 0) == 0));
            end
            if (!paused && bytes_sent >= 300)
            begin
                paused = 1'b1;
                await_results();
            end
        end
        steady = 1'b0;

        await_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Fed %0d EUC-JP bytes (%0d from the directed table), checked %0d bytes out.",
                 bytes_sent, table_rows, sjis_seen);
        $display("Texts terminated: %0d, including early ends, held leads and kana pairs.",
                 texts_closed);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
